// ===== hdl/wwe_pkg.sv =====
// Shared constants, types and controller encodings for the weighted effort block.
package wwe_pkg;

    // Default geometry
    localparam int WINDOW_DEF   = 10;
    localparam int CHANNELS_DEF = 8;

    // Field widths
    localparam int CH_W      = 3;
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 16;
    localparam int EFFORT_W  = 32;
    localparam int ACC_W     = 48;

    // Configuration space: one weight register per channel slot
    localparam int NUM_WEIGHTS = 8;
    localparam int REG_IDX_W   = 3;
    localparam int PADDR_W     = REG_IDX_W + 2;
    localparam int PDATA_W     = 32;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 16'sd2048;

    // Q.22 accumulator to Q16.16 output: divide by 64, then by WINDOW
    localparam int FRAC_SCALE = 64;

    typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] t_weights;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_MUL,
        S_ACC,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic update;
        logic mul;
        logic accum;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic in_ch_ok;
        logic in_frame_end;
        logic frame_end;
        logic div_last;
        logic out_busy;
    } t_status;

endpackage

// ===== hdl/wwe_stream_if.sv =====
// Valid/ready stream interfaces for sample words and effort words.
interface wwe_in_if
    import wwe_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] jerk_sample;
    logic                       frame_end;

    modport source (output valid, output channel, output jerk_sample, output frame_end,
                    input ready);
    modport sink   (input valid, input channel, input jerk_sample, input frame_end,
                    output ready);
endinterface

interface wwe_out_if
    import wwe_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [EFFORT_W-1:0] effort;

    modport source (output valid, output effort, input ready);
    modport sink   (input valid, input effort, output ready);
endinterface

// ===== hdl/wwe_regs.sv =====
// APB weight register file, one signed Q2.14 weight per channel.
module wwe_regs
    import wwe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_weights           o_weights
);

    t_weights             r_weights;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // Weight write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                r_weights[i] <= WEIGHT_RESET;
            end
        end else if (wr_en) begin
            r_weights[reg_idx] <= pwdata[WEIGHT_W-1:0];
        end
    end

    // Readback, sign extended
    assign prdata    = PDATA_W'(signed'(r_weights[reg_idx]));
    assign o_weights = r_weights;

endmodule

// ===== hdl/wwe_ctrl.sv =====
// Sequencing state machine: history clear, per-word update, frame divide.
module wwe_ctrl
    import wwe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.in_ch_ok)          n_state = S_UPD;
                    else if (i_status.in_frame_end) n_state = S_DIV_INIT;
                end
            end
            S_UPD:      n_state = S_MUL;
            S_MUL:      n_state = S_ACC;
            S_ACC: begin
                n_state = i_status.frame_end ? S_DIV_INIT : S_IDLE;
            end
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default:    n_state = S_CLEAR;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR:    o_cmd.clear_step = 1'b1;
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_UPD:      o_cmd.update   = 1'b1;
            S_MUL:      o_cmd.mul      = 1'b1;
            S_ACC:      o_cmd.accum    = 1'b1;
            S_DIV_INIT: o_cmd.div_init = 1'b1;
            S_DIV:      o_cmd.div_step = 1'b1;
            S_DONE:     o_cmd.finish   = !i_status.out_busy;
            default:    o_cmd          = '0;
        endcase
    end

endmodule

// ===== hdl/wwe_dp.sv =====
// Datapath: sample history RAM, window sums, multiply-accumulate, divider, output word.
module wwe_dp
    import wwe_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  t_weights                   i_weights,
    input  logic [CH_W-1:0]            i_channel,
    input  logic signed [SAMPLE_W-1:0] i_jerk_sample,
    input  logic                       i_frame_end,
    output logic                       o_out_valid,
    output logic signed [EFFORT_W-1:0] o_effort,
    input  logic                       i_out_ready
);

    localparam int DEPTH    = WINDOW * CHANNELS;
    localparam int MEM_AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
    localparam int PROD_W   = SUM_W + WEIGHT_W;
    localparam int DIV_D    = WINDOW * FRAC_SCALE;
    localparam int HALF_D   = DIV_D / 2;
    localparam int NUM_W    = ACC_W + 1;
    localparam int FRAC_SH  = $clog2(FRAC_SCALE);
    localparam int MAG_W    = NUM_W - FRAC_SH;
    localparam int CHUNK_W  = 16;
    localparam int NCHUNK   = (MAG_W + CHUNK_W - 1) / CHUNK_W;
    localparam int QUO_W    = NCHUNK * CHUNK_W;
    localparam int REM_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int DX_W     = REM_W + CHUNK_W;
    localparam int RECIP_SH = 28;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int DPROD_W  = DX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_C =
        RECIP_W'((2**RECIP_SH + WINDOW - 1) / WINDOW);
    localparam int DCNT_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    // History RAM
    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;
    logic [MEM_AW-1:0]   r_clr_addr;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [SAMPLE_W-1:0] mem_wdata;
    logic                mem_we;

    // Frame ring position
    logic [SLOT_W-1:0]   r_slot;
    logic [MEM_AW-1:0]   r_base;
    logic [MEM_AW-1:0]   acc_addr;

    // Latched word
    logic [MEM_AW-1:0]          r_addr;
    logic [CH_W-1:0]            r_ch;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_frame_end;

    // Window sums and MAC
    logic signed [SUM_W-1:0]    r_sums [CHANNELS];
    logic signed [SUM_W-1:0]    r_sum_new;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [WEIGHT_W-1:0] r_weight;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;

    // Divider
    logic signed [NUM_W-1:0] num_pos;
    logic signed [NUM_W-1:0] num_negm;
    logic [NUM_W-1:0]        num_mag;
    logic [QUO_W-1:0]        r_rq;
    logic [REM_W-1:0]        r_rem;
    logic                    r_neg;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [DX_W-1:0]         div_x;
    logic [DPROD_W-1:0]      div_prod;
    logic [CHUNK_W-1:0]      div_qd;
    logic [REM_W-1:0]        div_rem;

    // Output word
    logic                       r_out_valid;
    logic signed [EFFORT_W-1:0] r_effort;
    logic signed [EFFORT_W-1:0] n_effort;

    assign acc_addr = MEM_AW'(r_base + MEM_AW'(i_channel));

    // Status back to the controller
    assign o_status.clr_last     = (r_clr_addr == MEM_AW'(DEPTH - 1));
    assign o_status.in_ch_ok     = ({1'b0, i_channel} < (CH_W + 1)'(CHANNELS));
    assign o_status.in_frame_end = i_frame_end;
    assign o_status.frame_end    = r_frame_end;
    assign o_status.div_last     = (r_dcnt == DCNT_W'(NCHUNK - 1));
    assign o_status.out_busy     = r_out_valid;

    // RAM port: the clear sweep and the update share the write side
    always_comb begin
        mem_we    = i_cmd.clear_step | i_cmd.update;
        mem_waddr = i_cmd.clear_step ? r_clr_addr : r_addr;
        mem_wdata = i_cmd.clear_step ? '0 : r_sample;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept && o_status.in_ch_ok) begin
            r_rdata <= r_mem[acc_addr];
        end
    end

    // Clear sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step && !o_status.clr_last) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Capture accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_end <= 1'b0;
        end else if (i_cmd.accept) begin
            r_frame_end <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr   <= acc_addr;
            r_ch     <= i_channel;
            r_sample <= i_jerk_sample;
        end
    end

    // Window sum update: add new sample, drop the one it replaces
    assign n_sum = r_sums[r_ch[CH_IDX_W-1:0]] + SUM_W'(r_sample)
                   - SUM_W'(signed'(r_rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_sums[i] <= '0;
            end
        end else if (i_cmd.update) begin
            r_sums[r_ch[CH_IDX_W-1:0]] <= n_sum;
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_sum_new <= n_sum;
            r_weight  <= signed'(i_weights[r_ch]);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_sum_new) * PROD_W'(r_weight);
        end
    end

    // Accumulator, emptied when the divider takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.div_init) begin
            r_acc <= '0;
        end else if (i_cmd.accum) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Floor divide of (acc + D/2) by D: divide a magnitude, fix the sign after.
    // For a negative numerator the magnitude is rounded up: (D/2 - 1) - acc.
    // D = 64 * WINDOW: the 64 is a shift, WINDOW is divided a chunk at a time.
    assign num_pos  = NUM_W'(r_acc) + NUM_W'(HALF_D);
    assign num_negm = NUM_W'(HALF_D - 1) - NUM_W'(r_acc);
    assign num_mag  = num_pos[NUM_W-1] ? num_negm : num_pos;

    // Quotient digit of {remainder, chunk} / WINDOW by reciprocal multiply
    assign div_x    = {r_rem, r_rq[QUO_W-1 -: CHUNK_W]};
    assign div_prod = DPROD_W'(div_x) * DPROD_W'(RECIP_C);
    assign div_qd   = div_prod[RECIP_SH +: CHUNK_W];
    assign div_rem  = REM_W'(div_x - DX_W'(div_qd) * DX_W'(WINDOW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_init) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    // Long division by WINDOW, one 16-bit chunk per cycle, remainder carried down
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_neg <= num_pos[NUM_W-1];
            r_rq  <= QUO_W'(num_mag[NUM_W-1:FRAC_SH]);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rq  <= {r_rq[QUO_W-CHUNK_W-1:0], div_qd};
            r_rem <= div_rem;
        end
    end

    // Sign and saturate the quotient
    always_comb begin
        if (r_neg) begin
            if (r_rq > QUO_W'(64'h8000_0000)) begin
                n_effort = {1'b1, {(EFFORT_W-1){1'b0}}};
            end else begin
                n_effort = -signed'(r_rq[EFFORT_W-1:0]);
            end
        end else begin
            if (r_rq > QUO_W'(64'h7FFF_FFFF)) begin
                n_effort = {1'b0, {(EFFORT_W-1){1'b1}}};
            end else begin
                n_effort = signed'(r_rq[EFFORT_W-1:0]);
            end
        end
    end

    // Output word register and ring advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_slot      <= '0;
            r_base      <= '0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (r_slot == SLOT_W'(WINDOW - 1)) begin
                    r_slot <= '0;
                    r_base <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                    r_base <= MEM_AW'(r_base + MEM_AW'(CHANNELS));
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_effort <= n_effort;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_effort    = r_effort;

endmodule

// ===== hdl/windowed_weighted_effort.sv =====
// Top level: weighted moving-average effort over a multichannel frame stream.
//
//  port      dir   kind         contents
//  i_in      in    valid/ready  channel, jerk_sample (Q8.8), frame_end
//  o_out     out   valid/ready  effort (Q16.16, saturated), one word per frame
//  p*        in    APB          weight_ch0..7 at 4*i, Q2.14
//
// A sample for an in-range channel is handled in order: accept with history
// RAM read, sum update with RAM write-back, multiply, accumulate.
// A word carrying frame_end then rounds and drops the 64x scale, divides by
// WINDOW one 16-bit chunk at a time and loads the output word; that last
// step waits while a previous result is unread. After reset the history RAM
// is cleared one entry per cycle, for all WINDOW*CHANNELS entries, with input
// ready low; weight writes are taken throughout.
module windowed_weighted_effort
    import wwe_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    wwe_in_if.sink             i_in,
    wwe_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_weights weights;
    t_cmd     cmd;
    t_status  status;
    logic     in_ready;

    wwe_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_weights (weights)
    );

    wwe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wwe_dp #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_weights     (weights),
        .i_channel     (i_in.channel),
        .i_jerk_sample (i_in.jerk_sample),
        .i_frame_end   (i_in.frame_end),
        .o_out_valid   (o_out.valid),
        .o_effort      (o_out.effort),
        .i_out_ready   (o_out.ready)
    );

    assign i_in.ready = in_ready;

endmodule

// ===== hdl/wwe_chk.sv =====
// Port-level checks for the weighted effort block, bound to the top level.
module wwe_chk
    import wwe_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic signed [EFFORT_W-1:0] i_effort
);

    // A result word stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("effort word dropped while stalled");

    // Stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_effort))
        else $error("effort changed while stalled");

    // History clear runs after reset, so no word is taken right away
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during history clear");

    // A new result is loaded only while none is offered, so a taken word is not followed at once
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("back-to-back effort words");

endmodule

bind windowed_weighted_effort wwe_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_effort    (o_out.effort)
);

// ===== tb/tb_windowed_weighted_effort.sv =====
// Self-checking testbench for windowed_weighted_effort: stream stimulus, APB weights, scoreboard.
module tb_windowed_weighted_effort;
    import wwe_pkg::*;

    localparam int     REG_WEIGHT0    = 0;        // weight_ch0; weight_chN follows at index N
    localparam int     RANDOM_WORDS   = 800;
    localparam int     QUIET_AFTER    = 650;      // no idling once this many random words went in
    localparam int     BURST_MAX      = 14;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     SETTLE_CYCLES  = 64;
    localparam int     TIMEOUT_CYCLES = 400000;
    localparam int     LONG_FRAME     = 140;      // enough max-magnitude terms to pass 2^31
    localparam longint EFFORT_MAX     = 64'sd2147483647;
    localparam longint EFFORT_MIN     = -64'sd2147483648;

    // Directed rows; typed marks an effort that is written out by hand
    typedef struct packed {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       fe;
        logic                       typed;
        logic signed [EFFORT_W-1:0] eff;
    } t_row;

    localparam int N_ROWS = 20;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{3'd0, 16'sd0,     1'b1, 1'b1, 32'sd0},    // all history clear
        '{3'd0, 16'sd256,   1'b1, 1'b1, 32'sd819},  // 0.1 mean * 0.125
        '{3'd1, -16'sd64,   1'b1, 1'b1, 32'sd0},    // exact tie below zero rounds up
        '{3'd1, 16'sd128,   1'b1, 1'b1, 32'sd1},    // exact tie above zero rounds up
        '{3'd1, -16'sd129,  1'b1, 1'b1, -32'sd1},   // just past the tie rounds down
        '{3'd7, 16'sh8000,  1'b0, 1'b0, 32'sd0},
        '{3'd3, 16'sh7fff,  1'b0, 1'b0, 32'sd0},
        '{3'd5, 16'shffff,  1'b0, 1'b0, 32'sd0},
        '{3'd6, 16'sh1234,  1'b0, 1'b0, 32'sd0},
        '{3'd2, 16'sd100,   1'b0, 1'b0, 32'sd0},
        '{3'd2, -16'sd200,  1'b1, 1'b0, 32'sd0},    // same channel twice in a frame
        '{3'd4, 16'sh7fff,  1'b0, 1'b0, 32'sd0},
        '{3'd0, 16'sh8000,  1'b0, 1'b0, 32'sd0},
        '{3'd1, 16'sh8000,  1'b0, 1'b0, 32'sd0},
        '{3'd7, 16'sh7fff,  1'b1, 1'b0, 32'sd0},
        '{3'd6, 16'sh8000,  1'b1, 1'b0, 32'sd0},
        '{3'd5, 16'sh7fff,  1'b1, 1'b0, 32'sd0},
        '{3'd3, 16'sd0,     1'b1, 1'b0, 32'sd0},
        '{3'd2, 16'shffff,  1'b1, 1'b0, 32'sd0},    // first frame after the slot wraps to zero
        '{3'd0, 16'sd1,     1'b1, 1'b0, 32'sd0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    wwe_in_if  in_if ();
    wwe_out_if out_if ();

    windowed_weighted_effort dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Effort model state
    int     hist_mem [WINDOW_DEF*CHANNELS_DEF];
    int     win_sum [CHANNELS_DEF];
    int     weight_now [NUM_WEIGHTS];
    int     slot_now;
    longint acc_now;

    logic signed [EFFORT_W-1:0] effort_q [$];

    bit idle_on;
    bit hold_req;
    int words_sent;
    int random_words;
    int efforts_seen;
    int weight_writes;
    int sat_hi;
    int sat_lo;
    int bad_fields;
    int stray_words;
    int cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Moving-average weighted sum; returns 1 when the word closes a frame
    function automatic bit predict_effort(input logic [CH_W-1:0] ch,
                                          input logic signed [SAMPLE_W-1:0] smp,
                                          input logic fe,
                                          output logic signed [EFFORT_W-1:0] eff);
        int     pos;
        longint num;
        longint q;
        eff = '0;
        if (ch < CHANNELS_DEF && slot_now < WINDOW_DEF) begin
            pos = slot_now * CHANNELS_DEF + ch;
            win_sum[ch] = win_sum[ch] + int'(smp) - hist_mem[pos];
            hist_mem[pos] = int'(smp);
            acc_now = acc_now + longint'(win_sum[ch]) * longint'(weight_now[ch]);
        end
        if (!fe) return 1'b0;
        // round half up, then clamp to Q16.16
        num = acc_now + (WINDOW_DEF * FRAC_SCALE) / 2;
        q = num / (WINDOW_DEF * FRAC_SCALE);
        if ((num % (WINDOW_DEF * FRAC_SCALE)) != 0 && num < 0) q = q - 1;
        if (q > EFFORT_MAX) begin
            q = EFFORT_MAX;
            sat_hi++;
        end else if (q < EFFORT_MIN) begin
            q = EFFORT_MIN;
            sat_lo++;
        end
        eff = q[EFFORT_W-1:0];
        acc_now = 0;
        slot_now = (slot_now + 1 >= WINDOW_DEF) ? 0 : slot_now + 1;
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return $urandom_range(0, 1) ? 16'shffff : 16'sh0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one sample word, wait for acceptance, then record its expected effort
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp,
                               input logic fe, input bit typed,
                               input logic signed [EFFORT_W-1:0] typed_eff);
        logic signed [EFFORT_W-1:0] eff;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, BURST_MAX)) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.channel     <= ch;
        in_if.jerk_sample <= smp;
        in_if.frame_end   <= fe;
        do @(posedge i_clk); while (!in_if.ready);
        words_sent++;
        if (predict_effort(ch, smp, fe, eff))
            effort_q.insert(effort_q.size(), typed ? typed_eff : eff);
    endtask

    // APB write; psel stays up so writes can go back to back
    task automatic write_weight(input int ch, input logic signed [WEIGHT_W-1:0] w);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'((REG_WEIGHT0 + ch) * 4);
        pwdata  <= {{(PDATA_W-WEIGHT_W){w[WEIGHT_W-1]}}, w};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        weight_now[ch] = int'(w);
        weight_writes++;
    endtask

    task automatic release_bus();
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every expected effort is out and the block has gone quiet
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (effort_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_frame();
        int  n;
        bit  full;
        full = ($urandom_range(0, 6) == 0);
        n = full ? CHANNELS_DEF : $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            send_sample(full ? CH_W'(i) : CH_W'($urandom_range(0, 7)), pick_sample(),
                        i == n - 1, 1'b0, '0);
            random_words++;
        end
    endtask

    // Fill the window of channels 0..3 with one extreme, then one long frame of it
    task automatic saturate_run(input logic signed [WEIGHT_W-1:0] w,
                                input logic signed [SAMPLE_W-1:0] smp);
        for (int c = 0; c < NUM_WEIGHTS; c++) write_weight(c, w);
        release_bus();
        for (int f = 0; f < WINDOW_DEF; f++) begin
            for (int c = 0; c < 4; c++) send_sample(CH_W'(c), smp, c == 3, 1'b0, '0);
            random_words += 4;
        end
        for (int i = 0; i < LONG_FRAME; i++) begin
            send_sample(CH_W'($urandom_range(0, 3)), smp, i == LONG_FRAME - 1, 1'b0, '0);
            random_words++;
        end
    endtask

    // Result checker: every effort word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (effort_q.size() == 0) begin
                stray_words++;
                if (stray_words + bad_fields <= 10)
                    $display("[%0d] effort word %0d with nothing expected",
                             cycles, out_if.effort);
            end else begin
                if (out_if.effort !== effort_q[0]) begin
                    bad_fields++;
                    if (stray_words + bad_fields <= 10)
                        $display("[%0d] effort mismatch: expected %0d, got %0d",
                                 cycles, effort_q[0], out_if.effort);
                end
                void'(effort_q.pop_front());
                efforts_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d efforts outstanding",
                     cycles, effort_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Effort receiver: random stall bursts plus one long hold when asked
    initial begin : effort_sink
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_if.ready <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end else if (hold_left != 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                out_if.ready <= 1'b0;
                stall_left = $urandom_range(0, BURST_MAX - 1);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int phase;
        logic signed [WEIGHT_W-1:0] w;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.channel     = '0;
        in_if.jerk_sample = '0;
        in_if.frame_end   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        idle_on  = 1'b1;
        hold_req = 1'b0;
        for (int i = 0; i < WINDOW_DEF * CHANNELS_DEF; i++) hist_mem[i] = 0;
        for (int c = 0; c < CHANNELS_DEF; c++) win_sum[c] = 0;
        for (int c = 0; c < NUM_WEIGHTS; c++) weight_now[c] = int'(WEIGHT_RESET);
        slot_now = 0;
        acc_now  = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: channel 1 gets a tiny weight for the rounding ties
        write_weight(1, 16'sd5);
        release_bus();
        for (int r = 0; r < N_ROWS; r++)
            send_sample(DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].smp, DIRECTED_ROWS[r].fe,
                        DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].eff);
        settle();

        // Random phases, each with its own weight set
        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            idle_on = (random_words < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
            if (phase == 2) begin
                saturate_run(16'sh7fff, 16'sh7fff);
            end else if (phase == 4) begin
                saturate_run(16'sh7fff, 16'sh8000);
            end else begin
                for (int c = 0; c < NUM_WEIGHTS; c++) begin
                    if ($urandom_range(0, 3) == 0)
                        w = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    else
                        w = WEIGHT_W'($urandom);
                    write_weight(c, w);
                end
                release_bus();
                // output held off while words keep coming in
                if (phase == 1) hold_req = 1'b1;
                repeat ($urandom_range(6, 14)) random_frame();
            end
            settle();
            phase++;
        end

        $display("%0d sample words, %0d effort words checked, %0d weight writes, %0d phases",
                 words_sent, efforts_seen, weight_writes, phase);
        $display("saturated high %0d, low %0d; rounding ties, window wrap, output hold",
                 sat_hi, sat_lo);
        if (bad_fields == 0 && stray_words == 0 && effort_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d unexpected words, %0d missing",
                     bad_fields, stray_words, effort_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
